// ----- src/sdaf_pkg.sv -----
// Package for the signed decimal ASCII formatter.
// Holds the queue entry type, character codes and the error text table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdaf_pkg;

    localparam int VALUE_W     = 16;
    localparam int MAG_W       = 14;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VALUE_W-1:0] LIMIT     = 16'd9999;
    localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0]  CH_SPACE  = 8'h20;

    localparam logic [POS_W-1:0] POS_SIGN       = 3'd0;
    localparam logic [POS_W-1:0] POS_LAST_DIGIT = 3'd4;
    localparam logic [POS_W-1:0] POS_LAST_ERR   = 3'd5;

    typedef struct packed {
        logic             neg;
        logic             err;
        logic [MAG_W-1:0] mag;
    } item_t;

    function automatic logic [MAG_W-1:0] place_value(input logic [POS_W-1:0] pos);
        logic [MAG_W-1:0] pv;
        case (pos)
            3'd1:    pv = 14'd1000;
            3'd2:    pv = 14'd100;
            3'd3:    pv = 14'd10;
            3'd4:    pv = 14'd1;
            default: pv = 14'd0;
        endcase
        return pv;
    endfunction

    function automatic logic [CHAR_W-1:0] err_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h72;
            3'd3:    ch = 8'h72;
            3'd4:    ch = 8'h6F;
            3'd5:    ch = 8'h72;
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- src/sdaf_front.sv -----
// Front end of the formatter: splits a request into sign, range flag and magnitude.
// Depends on sdaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdaf_front (
    input  wire logic signed [15:0] value,
    output sdaf_pkg::item_t         item
);
    import sdaf_pkg::*;

    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;

    always_comb
    begin
        raw      = VALUE_W'(unsigned'(value));
        mag      = raw[VALUE_W-1] ? VALUE_W'(~raw + 16'd1) : raw;
        item.neg = raw[VALUE_W-1];
        item.err = (mag > LIMIT);
        item.mag = mag[MAG_W-1:0];
    end

endmodule

`default_nettype wire

// ----- src/sdaf_queue.sv -----
// Short request queue between the front end and the character sequencer.
// Depends on sdaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdaf_queue #(
    parameter int DEPTH = sdaf_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sdaf_pkg::item_t push_item,
    input  wire logic            pop,
    output sdaf_pkg::item_t      head,
    output logic                 nonempty,
    output logic                 full
);
    import sdaf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    item_t         slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == FULL_CNT);
    assign head     = slots_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : AW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : AW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/sdaf_back.sv -----
// Character sequencer: emits the sign, then one decimal digit or error letter per cycle.
// Digits are peeled off the magnitude by compare and subtract. Depends on sdaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdaf_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sdaf_pkg::item_t head,
    input  wire logic            nonempty,
    output logic                 pop,
    output logic [7:0]           character,
    output logic                 last,
    output logic                 strobe
);
    import sdaf_pkg::*;

    logic             active_reg, active_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             neg_reg, neg_next;
    logic             err_reg, err_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] div_sel;
    logic [MAG_W-1:0] thr;
    logic [MAG_W-1:0] sub_val;
    logic [3:0]       digit;
    logic             finish;

    always_comb
    begin
        integer k;
        div_sel = place_value(pos_reg);
        digit   = 4'd0;
        sub_val = '0;
        thr     = '0;
        for (k = 1; k <= 9; k++)
        begin
            thr = MAG_W'(MAG_W'(k) * div_sel);
            if (rem_reg >= thr)
            begin
                digit   = 4'(k);
                sub_val = thr;
            end
        end
    end

    always_comb
    begin
        if (pos_reg == POS_SIGN)
        begin
            character = neg_reg ? CH_MINUS : CH_SPACE;
        end
        else if (err_reg)
        begin
            character = err_char(pos_reg);
        end
        else
        begin
            character = CH_ZERO + CHAR_W'(digit);
        end
        last   = err_reg ? (pos_reg == POS_LAST_ERR) : (pos_reg == POS_LAST_DIGIT);
        strobe = active_reg;
        finish = active_reg && last;
        pop    = (!active_reg || finish) && nonempty;
    end

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        neg_next    = neg_reg;
        err_next    = err_reg;
        rem_next    = rem_reg;
        if (!active_reg || finish)
        begin
            active_next = nonempty;
            pos_next    = POS_SIGN;
            neg_next    = head.neg;
            err_next    = head.err;
            rem_next    = head.mag;
        end
        else
        begin
            pos_next = POS_W'(pos_reg + 1'b1);
            rem_next = MAG_W'(rem_reg - sub_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= POS_SIGN;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        err_reg <= err_next;
        rem_reg <= rem_next;
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !err_reg |-> pos_reg <= POS_LAST_DIGIT)
        else $error("Digit position ran past the last digit.");

    a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && pos_reg == $past(pos_reg) + 3'd1)
        else $error("Character run was broken before its last character.");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !err_reg |-> rem_reg <= MAG_W'(LIMIT))
        else $error("Remaining magnitude left the four digit range.");

    a_sign_char: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && pos_reg == POS_SIGN |-> character == CH_MINUS || character == CH_SPACE)
        else $error("First character of a run is not a sign.");

endmodule

`default_nettype wire

// ----- src/signed_decimal_ascii_formatter_top.sv -----
// The sign character is strobed after the request has gone through the queue registers
// and the sequencer's active register. One character per cycle goes out during a run;
// 5 characters per in-range value, 6 per error value. A queue of QUEUE_DEPTH requests
// lets start be taken while a run is still going out; busy is high while the queue is full.
// Reset clears the queue and the sequencer at once; results cannot be stalled.
// Depends on sdaf_pkg, sdaf_front, sdaf_queue and sdaf_back.
`timescale 1ns / 1ps
`default_nettype none

module signed_decimal_ascii_formatter_top #(
    parameter int QUEUE_DEPTH = sdaf_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] value,
    output logic [7:0]              character,
    output logic                    last,
    output logic                    strobe
);
    import sdaf_pkg::*;

    item_t front_item;
    item_t head;
    logic  nonempty;
    logic  full;
    logic  pop;

    assign busy = full;

    sdaf_front u_front (
        .value (value),
        .item  (front_item)
    );

    sdaf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_item (front_item),
        .pop       (pop),
        .head      (head),
        .nonempty  (nonempty),
        .full      (full)
    );

    sdaf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .nonempty  (nonempty),
        .pop       (pop),
        .character (character),
        .last      (last),
        .strobe    (strobe)
    );

endmodule

`default_nettype wire
